### rtl/r64_pkg.sv
// Package for the radix-64 text encoder: symbol index types, alphabet constants and lookup.
`default_nettype none

package r64_pkg;

    // Six-bit index into the 64-symbol alphabet.
    typedef logic [5:0] t_sym_idx;

    // Seven-bit ASCII character code.
    typedef logic [6:0] t_ascii;

    // Alphabet segment bounds and base codes.
    localparam t_sym_idx SYM_UPPER_START = 6'd10;
    localparam t_sym_idx SYM_LOWER_START = 6'd36;
    localparam t_sym_idx SYM_PLUS        = 6'd62;
    localparam t_sym_idx SYM_SLASH       = 6'd63;

    localparam t_ascii ASCII_DIGIT_ZERO = 7'h30;
    localparam t_ascii ASCII_UPPER_A    = 7'h41;
    localparam t_ascii ASCII_LOWER_A    = 7'h61;
    localparam t_ascii ASCII_PLUS       = 7'h2B;
    localparam t_ascii ASCII_SLASH      = 7'h2F;

    // Mask that selects the six bits of one character.
    localparam logic [11:0] SIX_BIT_MASK = 12'h03F;

    // Map a symbol index to its ASCII code: digits, upper case, lower case, '+', '/'.
    function automatic t_ascii sym_to_ascii(input t_sym_idx idx);
        t_ascii code;
        if (idx < SYM_UPPER_START) begin
            code = ASCII_DIGIT_ZERO + {1'b0, idx};
        end else if (idx < SYM_LOWER_START) begin
            code = ASCII_UPPER_A + {1'b0, idx - SYM_UPPER_START};
        end else if (idx < SYM_PLUS) begin
            code = ASCII_LOWER_A + {1'b0, idx - SYM_LOWER_START};
        end else if (idx == SYM_PLUS) begin
            code = ASCII_PLUS;
        end else begin
            code = ASCII_SLASH;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

### rtl/r64_if.sv
// Valid/ready channel interfaces for the byte input and the character output.
`default_nettype none

interface r64_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface r64_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

### rtl/radix64_lsb_text_encoder_top.sv
// Top level of the radix-64 text encoder: bit packing, symbol pair buffer and output register.
// A byte's first character goes through the symbol pair buffer and the output register, and
// a second one follows it. Throughput: one character per cycle unless the output stalls;
// a byte yielding one character is taken every cycle; a byte yielding two (every last byte,
// and every third) fills the buffer, so the next byte waits until the first has left it.
// The single output register that drains the two-entry symbol buffer sets that rate.
// Reset (i_rst_n low, synchronous) empties both stages and clears the held bits.
`default_nettype none

module radix64_lsb_text_encoder_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    r64_byte_if.sink    i_byte,
    r64_char_if.source  o_char
);

    // Packing state: up to four held bits and their count (0, 2 or 4).
    logic [3:0]  r_acc,  n_acc;
    logic [2:0]  r_held, n_held;

    // Symbol pair buffer between packing and the output register.
    logic [1:0]          r_a_cnt,   n_a_cnt;
    r64_pkg::t_sym_idx   r_a_sym0,  n_a_sym0;
    r64_pkg::t_sym_idx   r_a_sym1,  n_a_sym1;
    logic                r_a_mark0, n_a_mark0;
    logic                r_a_mark1, n_a_mark1;

    // Output register.
    logic                r_o_valid;
    r64_pkg::t_ascii     r_o_char;
    logic                r_o_last;

    logic        in_accept;
    logic        out_take;
    logic        move;
    logic [11:0] acc_full;
    logic        two_syms;

    // Handshake control: the buffer slot frees when its last symbol moves on.
    assign out_take      = !r_o_valid || o_char.ready;
    assign move          = (r_a_cnt != 2'd0) && out_take;
    assign i_byte.ready  = (r_a_cnt == 2'd0) || ((r_a_cnt == 2'd1) && move);
    assign in_accept     = i_byte.valid && i_byte.ready;

    // Merge the new byte above the held bits, least significant bits first.
    assign acc_full = (({4'b0000, i_byte.data_byte} << r_held) | {8'b0, r_acc})
                      & {r64_pkg::SIX_BIT_MASK[5:0], r64_pkg::SIX_BIT_MASK[5:0]};
    assign two_syms = (r_held == 3'd4) || i_byte.last_byte;

    // Next packing state.
    always_comb begin
        n_acc  = r_acc;
        n_held = r_held;
        if (in_accept) begin
            if (two_syms) begin
                n_acc  = 4'd0;
                n_held = 3'd0;
            end else begin
                n_acc  = acc_full[9:6];
                n_held = r_held + 3'd2;
            end
        end
    end

    // Next buffer contents: load a new pair, or shift the second symbol down.
    always_comb begin
        n_a_cnt   = r_a_cnt;
        n_a_sym0  = r_a_sym0;
        n_a_sym1  = r_a_sym1;
        n_a_mark0 = r_a_mark0;
        n_a_mark1 = r_a_mark1;
        if (in_accept) begin
            n_a_cnt   = two_syms ? 2'd2 : 2'd1;
            n_a_sym0  = acc_full[5:0];
            n_a_sym1  = acc_full[11:6];
            n_a_mark0 = 1'b0;
            n_a_mark1 = i_byte.last_byte;
        end else if (move) begin
            n_a_cnt   = r_a_cnt - 2'd1;
            n_a_sym0  = r_a_sym1;
            n_a_mark0 = r_a_mark1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 4'd0;
            r_held    <= 3'd0;
            r_a_cnt   <= 2'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_held  <= n_held;
            r_a_cnt <= n_a_cnt;
            if (out_take) begin
                r_o_valid <= (r_a_cnt != 2'd0);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_a_sym0  <= n_a_sym0;
        r_a_sym1  <= n_a_sym1;
        r_a_mark0 <= n_a_mark0;
        r_a_mark1 <= n_a_mark1;
        if (move) begin
            r_o_char <= r64_pkg::sym_to_ascii(r_a_sym0);
            r_o_last <= r_a_mark0;
        end
    end

    // Output channel.
    assign o_char.valid     = r_o_valid;
    assign o_char.text_char = r_o_char;
    assign o_char.last_char = r_o_last;

    // A last byte always leaves a full pair whose second symbol is marked.
    a_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_byte.last_byte |=> (r_a_cnt == 2'd2) && r_a_mark1)
        else $error("last byte did not load a marked symbol pair");

    // The packing state is clear after a last byte.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_byte.last_byte |=> (r_held == 3'd0) && (r_acc == 4'd0))
        else $error("packing state not cleared after last byte");

    // The held bit count stays at 0, 2 or 4.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == 3'd0) || (r_held == 3'd2) || (r_held == 3'd4))
        else $error("held bit count out of range");

    // A full buffer never takes a new item.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_cnt == 2'd2) |-> !i_byte.ready)
        else $error("input ready while symbol buffer is full");

endmodule

`default_nettype wire

### tb/r64_encode_compare.sv
// Predicts the encoder's characters from accepted bytes and compares them with the output channel.
`timescale 1ns / 100ps

module r64_encode_compare (
    input  wire    i_clk,
    input  wire    i_rst_n,
    r64_byte_if    i_byte_ch,
    r64_char_if    i_char_ch,
    output int     o_fail_count,
    output int     o_pending
);

    // One expected character on the output channel.
    typedef struct packed {
        r64_pkg::t_ascii text_char;
        logic            last_char;
    } t_text_symbol;

    // The 64 symbols in index order; index 0 sits in the top byte of the literal.
    localparam logic [8*64-1:0] ALPHABET =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";

    t_text_symbol awaited_chars[$];
    logic [11:0]  packed_bits;
    logic [3:0]   held_bits;
    int           fail_total = 0;

    // Queue the character for one six-bit index.
    function automatic void queue_symbol(input r64_pkg::t_sym_idx idx, input logic mark);
        r64_pkg::t_ascii code;
        code = ALPHABET[8 * (63 - int'(idx)) +: 7];
        awaited_chars.push_back(t_text_symbol'{code, mark});
    endfunction

    // Pack one byte above the held bits, then emit every complete character,
    // plus a zero-padded one for leftover bits when the message ends.
    task automatic pack_byte(input logic [7:0] data, input logic is_last);
        logic [11:0] bits;
        logic [4:0]  count;
        bits  = packed_bits | (12'(data) << held_bits);
        count = 5'(held_bits) + 5'd2;
        queue_symbol(bits[5:0], 1'b0);
        bits = bits >> 6;
        if (count >= 5'd6) begin
            queue_symbol(bits[5:0], is_last);
            bits  = bits >> 6;
            count = count - 5'd6;
        end else if (is_last && count != 5'd0) begin
            queue_symbol(bits[5:0], 1'b1);
        end
        if (is_last) begin
            bits  = '0;
            count = '0;
        end
        packed_bits = bits;
        held_bits   = count[3:0];
    endtask

    // Compare each accepted character with the oldest expectation, then
    // predict the characters of an accepted byte.
    always @(posedge i_clk) begin
        t_text_symbol want;
        if (!i_rst_n) begin
            awaited_chars.delete();
            packed_bits = '0;
            held_bits   = '0;
        end else begin
            if (i_char_ch.valid && i_char_ch.ready) begin
                if (awaited_chars.size() == 0) begin
                    $error("unexpected character: text_char %0d, last_char %0d",
                           i_char_ch.text_char, i_char_ch.last_char);
                    fail_total++;
                end else begin
                    want = awaited_chars.pop_front();
                    if (i_char_ch.text_char !== want.text_char) begin
                        $error("text_char: expected %0d, actual %0d",
                               want.text_char, i_char_ch.text_char);
                        fail_total++;
                    end
                    if (i_char_ch.last_char !== want.last_char) begin
                        $error("last_char: expected %0d, actual %0d",
                               want.last_char, i_char_ch.last_char);
                        fail_total++;
                    end
                end
            end
            if (i_byte_ch.valid && i_byte_ch.ready) begin
                pack_byte(i_byte_ch.data_byte, i_byte_ch.last_byte);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_chars.size();
    end

endmodule

### tb/tb_radix64_lsb_text_encoder_top.sv
// Stimulus, clock, reset and verdict for the radix-64 text encoder testbench.
`timescale 1ns / 100ps

module tb_radix64_lsb_text_encoder_top;

    localparam int RANDOM_BYTES = 850;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PERCENT = 20;

    // Directed messages as {last_byte, data_byte}: single-byte messages at the
    // extremes, the '+' and '/' symbols, and messages ending with 0, 2 and 4
    // bits held so every flush shape is covered.
    localparam logic [8:0] DIRECTED_BYTES [21] = '{
        9'h100,
        9'h1FF,
        9'h03F, 9'h13E,
        9'h0FF, 9'h0FF, 9'h1FF,
        9'h000, 9'h000, 9'h100,
        9'h0AA, 9'h055, 9'h0C3, 9'h03C, 9'h181,
        9'h07E, 9'h001, 9'h080, 9'h03E, 9'h0FE, 9'h10F
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   calm_phase = 1'b0;
    int   fail_count;
    int   pending_count;
    int   idle_cycles = 0;

    r64_byte_if byte_ch ();
    r64_char_if char_ch ();

    radix64_lsb_text_encoder_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch)
    );

    r64_encode_compare u_compare (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_ch    (byte_ch),
        .i_char_ch    (char_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side stalls at random, except during the calm stretch.
    always @(negedge i_clk) begin
        char_ch.ready <= i_rst_n &&
                         (calm_phase || $urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Offer one byte, with random gaps ahead of it; starts and ends just after
    // a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic is_last);
        while (!calm_phase && $urandom_range(0, 99) < IDLE_PERCENT) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= data;
        byte_ch.last_byte <= is_last;
        do begin
            @(posedge i_clk);
        end while (!byte_ch.ready);
        @(negedge i_clk);
    endtask

    // Main stimulus and verdict.
    initial begin
        int sent;
        int msg_len;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        sent              = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_BYTES[k]) begin
            send_byte(DIRECTED_BYTES[k][7:0], DIRECTED_BYTES[k][8]);
        end

        // Random messages, mostly of moderate length with some very short ones.
        while (sent < RANDOM_BYTES) begin
            if ($urandom_range(0, 3) == 0) begin
                msg_len = $urandom_range(1, 3);
            end else begin
                msg_len = $urandom_range(1, 16);
            end
            for (int n = 0; n < msg_len; n++) begin
                calm_phase = (sent >= 350 && sent < 500);
                send_byte(8'($urandom_range(0, 255)), n == msg_len - 1);
                sent++;
            end
        end
        calm_phase = 1'b0;
        byte_ch.valid <= 1'b0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog: ends the run when neither channel moves for too long.
    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((byte_ch.valid && byte_ch.ready) || (char_ch.valid && char_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("FAILED: results differ");
        $finish;
    end

endmodule
